/* hdl/deq_pkg.sv */
// Package for the double-ended queue: depth, derived widths and codes.
// Holds the operation, status and controller state types.
// Has no dependencies; imported by double_ended_queue.
package deq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam int KIND_W      = 3;
  localparam int ITEM_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int ITEM_CNT_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4
  } op_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_RESP = 2'd2
  } deq_state_t;

endpackage

/* hdl/double_ended_queue.sv */
// Bounded double-ended queue of 8-bit items in a ring memory of DEPTH entries.
// Each input beat performs one operation (push front, push back, pop front,
// pop back, clear) and yields one output beat with the status, the front and
// back items, the count and an empty flag. An accepted item first updates the
// pointers and writes the memory, then the front and back entries are read
// into registers, and the registered read data then reaches the output
// register once that register is free or drains. The next input beat is
// taken while the previous result still waits in the output register.
// Depends on deq_pkg.
module double_ended_queue
  import deq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [ITEM_W-1:0]     in_value,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [ITEM_W-1:0]     out_front_item,
  output logic [ITEM_W-1:0]     out_back_item,
  output logic [ITEM_CNT_W-1:0] out_item_count,
  output logic                  out_is_empty
);

  logic [ITEM_W-1:0] mem [DEPTH];

  deq_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  status_t           status_r, status_nxt;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  back_addr;
  logic              in_accept;
  logic              out_load;
  logic              full;
  logic              empty;

  logic [ITEM_W-1:0]     rd_front_r, rd_back_r;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [ITEM_W-1:0]     out_front_r, out_back_r;
  logic [ITEM_CNT_W-1:0] out_count_r;
  logic                  out_empty_r;

  // Ring index of head + offset, where the sum stays below twice the depth.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W:0]   off);
    logic [IDX_W:0] s;
    logic [IDX_W:0] t;
    s = {1'b0, base} + off;
    t = (s >= (IDX_W+1)'(DEPTH)) ? s - (IDX_W+1)'(DEPTH) : s;
    return t[IDX_W-1:0];
  endfunction

  assign in_accept = in_valid && !in_stall;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);

  // Back entry after the operation; the offset is count - 1, or 0 if empty.
  assign back_addr = wrap_add(head_r, empty ? '0 : (IDX_W+1)'(count_r - 1'b1));

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    in_stall   = 1'b1;
    out_load   = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt  = S_READ;
          status_nxt = ST_DONE;
          case (op_kind_t'(in_kind))
            OP_PUSH_FRONT: begin
              if (full) begin
                status_nxt = ST_PUSH_FULL;
              end else begin
                head_nxt  = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - 1'b1;
                wr_en     = 1'b1;
                wr_addr   = head_nxt;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                status_nxt = ST_PUSH_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = wrap_add(head_r, (IDX_W+1)'(count_r));
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                status_nxt = ST_POP_EMPTY;
              end else begin
                head_nxt  = (head_r == IDX_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                status_nxt = ST_POP_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            OP_CLEAR: begin
              head_nxt  = '0;
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // Load the result once the output register is free or drains now.
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      status_r    <= ST_DONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_load || (out_valid_r && out_stall);
    end
  end

  // Ring memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en && in_accept) begin
      mem[wr_addr] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rd_front_r <= mem[head_r];
      rd_back_r  <= mem[back_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_front_r  <= empty ? '0 : rd_front_r;
      out_back_r   <= empty ? '0 : rd_back_r;
      out_count_r  <= ITEM_CNT_W'(count_r);
      out_empty_r  <= empty;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_front_item = out_front_r;
  assign out_back_item  = out_back_r;
  assign out_item_count = out_count_r;
  assign out_is_empty   = out_empty_r;

  // The fill count never passes the depth and the head stays in the ring.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(DEPTH)) && (head_r <= IDX_W'(DEPTH - 1)))
    else $error("deque pointer or count out of range");

  // An accepted beat always moves on to the memory read.
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_READ))
    else $error("accepted beat did not start a read");

  // A result is loaded only when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !out_load)
    else $error("stalled output beat overwritten");

  // An empty result carries zero items and zero count.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |->
      (out_item_count == '0) && (out_front_item == '0) && (out_back_item == '0))
    else $error("empty result with nonzero fields");

endmodule
